[rtl/core/lfu_pkg.sv]
// Shared types and constants for the LFU cache replacement block.
// Standalone package; used by lfu_cache_replacement_top.
`timescale 1ns / 1ps

package lfu_pkg;

  // Fixed field widths
  localparam int KEY_PORT_W = 32;
  localparam int COUNT_W    = 32;
  localparam int STAMP_W    = 32;
  localparam int TOTAL_W    = 32;
  localparam int TIME_W     = 40;
  localparam int CAP_W      = 4;

  // Reset value of the capacity register
  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  // Access time charged per request, in ms
  localparam logic [TIME_W-1:0] HIT_MS   = 40'd1;
  localparam logic [TIME_W-1:0] MISS_MS  = 40'd100;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

[rtl/core/lfu_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lfu_cache_replacement_top.sv]
// One request at a time: requests are accepted only in idle, after the
//   previous one has committed. The entry RAM has one read port and the
//   sequencer scans it one entry per cycle for key match, minimum (count,
//   stamp) and first free slot, then commits once the result register frees.
// Reset: valid bits, counters, occupancy and use clock clear, capacity reads 8.
// Depends on lfu_pkg and lfu_ram.
`timescale 1ns / 1ps

module lfu_cache_replacement_top
  import lfu_pkg::*;
#(
  parameter int ENTRIES  = 8,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration
  input  logic                  cfg_we_i,
  input  logic [CAP_W-1:0]      cfg_wdata_i,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [KEY_PORT_W-1:0] key_i,
  input  logic                  in_store_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  hit_o,
  output logic                  inserted_o,
  output logic                  evicted_valid_o,
  output logic [KEY_PORT_W-1:0] evicted_key_o,
  output logic [TOTAL_W-1:0]    hit_total_o,
  output logic [TOTAL_W-1:0]    miss_total_o,
  output logic [TIME_W-1:0]     time_total_ms_o
);

  localparam int KW   = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (SW > CAP_W) ? SW : CAP_W;
  localparam int RW   = KW + COUNT_W + STAMP_W;

  // Sequencer
  state_e state_q, state_d;
  logic   accept, commit, scan_done;

  // Request registers
  logic          req_type_q;
  logic [KW-1:0] req_key_q;
  logic          req_store_q;

  // Scan state
  logic [SW-1:0]      cnt_q;
  logic [SW-1:0]      cnt_m1;
  logic [AW-1:0]      eval_idx;
  logic               match_q;
  logic [AW-1:0]      match_idx_q;
  logic [COUNT_W-1:0] match_cnt_q;
  logic               min_have_q;
  logic [AW-1:0]      min_idx_q;
  logic [KW-1:0]      min_key_q;
  logic [COUNT_W-1:0] min_cnt_q;
  logic [STAMP_W-1:0] min_stamp_q;
  logic               free_have_q;
  logic [AW-1:0]      free_idx_q;

  // Cache state
  logic [ENTRIES-1:0] valid_q;
  logic [SW-1:0]      occ_q;
  logic [STAMP_W-1:0] use_clock_q;
  logic [CAP_W-1:0]   cap_q;
  logic [TOTAL_W-1:0] hits_q;
  logic [TOTAL_W-1:0] misses_q;
  logic [TIME_W-1:0]  time_q;

  // Result register
  logic              out_valid_q;
  logic              res_hit_q;
  logic              res_ins_q;
  logic              res_ev_q;
  logic [KW-1:0]     res_ev_key_q;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic [KW-1:0]      rd_key;
  logic [COUNT_W-1:0] rd_cnt;
  logic [STAMP_W-1:0] rd_stamp;
  logic               lane_on;
  logic               lane_valid;
  logic               lane_match;
  logic               lane_less;

  // Commit decisions
  logic [CMPW-1:0]    cap_eff;
  logic [CMPW-1:0]    cap_ext;
  logic [CMPW-1:0]    occ_ext;
  logic               cap_zero;
  logic               do_touch;
  logic               try_ins;
  logic               do_evict;
  logic               do_ins;
  logic [AW-1:0]      ins_slot;
  logic [COUNT_W-1:0] touch_cnt;
  logic [TIME_W-1:0]  time_add;
  logic [TIME_W-1:0]  time_next;

  lfu_ram #(
    .WIDTH (RW),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    commit     = 1'b0;
    scan_done  = (cnt_q == SW'(ENTRIES));
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        commit = !out_valid_q || out_ready_i;
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Evaluate the entry whose read data returns this cycle
  assign cnt_m1     = cnt_q - SW'(1);
  assign eval_idx   = cnt_m1[AW-1:0];
  assign rd_key     = ram_rdata[RW-1 -: KW];
  assign rd_cnt     = ram_rdata[STAMP_W +: COUNT_W];
  assign rd_stamp   = ram_rdata[STAMP_W-1:0];
  assign lane_on    = (state_q == ST_SCAN) && (cnt_q != '0);
  assign lane_valid = valid_q[eval_idx];
  assign lane_match = lane_on && lane_valid && (rd_key == req_key_q);
  assign lane_less  = {rd_cnt, rd_stamp} < {min_cnt_q, min_stamp_q};

  // Scan counter, request capture and running search results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      match_q     <= 1'b0;
      min_have_q  <= 1'b0;
      free_have_q <= 1'b0;
    end else if (accept) begin
      cnt_q       <= '0;
      match_q     <= 1'b0;
      min_have_q  <= 1'b0;
      free_have_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      if (!scan_done) begin
        cnt_q <= cnt_q + SW'(1);
      end
      if (lane_match && !match_q) begin
        match_q <= 1'b1;
      end
      if (lane_on && lane_valid && (!min_have_q || lane_less)) begin
        min_have_q <= 1'b1;
      end
      if (lane_on && !lane_valid && !free_have_q) begin
        free_have_q <= 1'b1;
      end
    end
  end

  // Payload of the scan: indexes, keys and counts
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q  <= req_type_i;
      req_key_q   <= key_i[KW-1:0];
      req_store_q <= in_store_i;
    end
    if (lane_match && !match_q) begin
      match_idx_q <= eval_idx;
      match_cnt_q <= rd_cnt;
    end
    if (lane_on && lane_valid && (!min_have_q || lane_less)) begin
      min_idx_q   <= eval_idx;
      min_key_q   <= rd_key;
      min_cnt_q   <= rd_cnt;
      min_stamp_q <= rd_stamp;
    end
    if (lane_on && !lane_valid && !free_have_q) begin
      free_idx_q <= eval_idx;
    end
  end

  // Decide hit update, eviction and insertion
  always_comb begin
    cap_ext   = CMPW'(cap_q);
    cap_eff   = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
    occ_ext   = CMPW'(occ_q);
    cap_zero  = (cap_eff == '0);
    do_touch  = match_q && (req_type_q == REQ_READ || !cap_zero);
    try_ins   = !match_q && (req_type_q == REQ_READ) && req_store_q && !cap_zero;
    do_evict  = try_ins && (occ_ext >= cap_eff) && min_have_q;
    do_ins    = try_ins && (do_evict || free_have_q);
    ins_slot  = do_evict ? min_idx_q : free_idx_q;
    touch_cnt = (match_cnt_q == {COUNT_W{1'b1}}) ? match_cnt_q
                                                 : match_cnt_q + COUNT_W'(1);
    time_add  = match_q ? HIT_MS : MISS_MS;
    time_next = (time_q > TIME_MAX - time_add) ? TIME_MAX : time_q + time_add;

    ram_we    = commit && (do_touch || do_ins);
    ram_waddr = do_touch ? match_idx_q : ins_slot;
    ram_wdata = do_touch ? {req_key_q, touch_cnt, use_clock_q}
                         : {req_key_q, COUNT_W'(1), use_clock_q};
  end

  // Commit cache state, counters and the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      use_clock_q <= '0;
      cap_q       <= CAP_RESET;
      hits_q      <= '0;
      misses_q    <= '0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        time_q      <= time_next;
        if (match_q) begin
          if (hits_q != {TOTAL_W{1'b1}}) begin
            hits_q <= hits_q + TOTAL_W'(1);
          end
        end else if (misses_q != {TOTAL_W{1'b1}}) begin
          misses_q <= misses_q + TOTAL_W'(1);
        end
        if (do_touch || do_ins) begin
          use_clock_q <= use_clock_q + STAMP_W'(1);
        end
        if (do_ins) begin
          valid_q[ins_slot] <= 1'b1;
          if (!do_evict) begin
            occ_q <= occ_q + SW'(1);
          end
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      res_hit_q    <= match_q;
      res_ins_q    <= do_ins;
      res_ev_q     <= do_evict;
      res_ev_key_q <= do_evict ? min_key_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = res_hit_q;
  assign inserted_o      = res_ins_q;
  assign evicted_valid_o = res_ev_q;
  assign evicted_key_o   = KEY_PORT_W'(res_ev_key_q);
  assign hit_total_o     = hits_q;
  assign miss_total_o    = misses_q;
  assign time_total_ms_o = time_q;

endmodule

[tb/sv/lfu_cache_replacement_top_tb.sv]
// Self-checking testbench for lfu_cache_replacement_top: drives LFU cache requests,
// predicts every result in a scoreboard class, and compares field by field.
// Depends on lfu_pkg and the cache RTL only.
`timescale 1ns / 1ps

module lfu_cache_replacement_top_tb;
  import lfu_pkg::*;

  localparam int          ENTRIES_TB   = 8;
  localparam int          LATENCY      = ENTRIES_TB + 3;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned PRESSURE_AT  = 250;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 58;
  localparam int          POOL_SIZE    = 12;

  typedef struct packed {
    logic                  hit;
    logic                  inserted;
    logic                  evicted_valid;
    logic [KEY_PORT_W-1:0] evicted_key;
    logic [TOTAL_W-1:0]    hit_total;
    logic [TOTAL_W-1:0]    miss_total;
    logic [TIME_W-1:0]     time_total_ms;
  } access_result_t;

  // Shadow copy of the cache that predicts each access outcome
  class lfu_access_tracker;
    logic [CAP_W-1:0]      capacity;
    bit                    slot_valid[ENTRIES_TB];
    logic [KEY_PORT_W-1:0] slot_key[ENTRIES_TB];
    bit [COUNT_W-1:0]      slot_count[ENTRIES_TB];
    bit [STAMP_W-1:0]      slot_stamp[ENTRIES_TB];
    bit [STAMP_W-1:0]      use_clock;
    int unsigned           occupancy;
    bit [TOTAL_W-1:0]      hits;
    bit [TOTAL_W-1:0]      misses;
    bit [TIME_W-1:0]       time_ms;
    access_result_t        pending_results[$];
    int unsigned           mismatches;

    function new();
      capacity    = CAP_RESET;
      use_clock   = '0;
      occupancy   = 0;
      hits        = '0;
      misses      = '0;
      time_ms     = '0;
      mismatches  = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    // Apply one accepted request to the shadow cache and queue its outcome
    function void note_request(logic kind, logic [KEY_PORT_W-1:0] req_key, logic stored);
      int             found;
      int             slot;
      int unsigned    cap;
      bit [TIME_W-1:0] add;
      access_result_t r;
      cap   = (capacity > ENTRIES_TB) ? ENTRIES_TB : capacity;
      r     = '0;
      found = -1;
      for (int i = 0; i < ENTRIES_TB; i++) begin
        if (found < 0 && slot_valid[i] && slot_key[i] == req_key) found = i;
      end
      if (found >= 0) begin
        // hit: bump count and stamp, except a write with caching disabled
        r.hit = 1'b1;
        if (kind == REQ_READ || cap != 0) begin
          if (slot_count[found] != '1) slot_count[found]++;
          slot_stamp[found] = use_clock;
          use_clock++;
        end
      end else if (kind == REQ_READ && stored && cap != 0) begin
        slot = -1;
        // evict lowest count, oldest stamp on a tie
        if (occupancy >= cap) begin
          for (int i = 0; i < ENTRIES_TB; i++) begin
            if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                (slot_count[i] == slot_count[slot] && slot_stamp[i] < slot_stamp[slot])))
              slot = i;
          end
          if (slot >= 0) begin
            r.evicted_valid    = 1'b1;
            r.evicted_key      = slot_key[slot];
            slot_valid[slot]   = 1'b0;
            occupancy--;
          end
        end
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES_TB; i++) begin
            if (slot < 0 && !slot_valid[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          slot_valid[slot] = 1'b1;
          slot_key[slot]   = req_key;
          slot_count[slot] = 1;
          slot_stamp[slot] = use_clock;
          use_clock++;
          occupancy++;
          r.inserted = 1'b1;
        end
      end
      // saturating hit/miss counters and access time
      if (r.hit) begin
        if (hits != '1) hits++;
        add = HIT_MS;
      end else begin
        if (misses != '1) misses++;
        add = MISS_MS;
      end
      time_ms = (time_ms > TIME_MAX - add) ? TIME_MAX : time_ms + add;
      r.hit_total     = hits;
      r.miss_total    = misses;
      r.time_total_ms = time_ms;
      pending_results = {pending_results, r};
    endfunction

    function void compare_field(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one delivered result against the oldest prediction
    function void check_result(access_result_t got);
      access_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("hit", TIME_W'(want.hit), TIME_W'(got.hit));
      compare_field("inserted", TIME_W'(want.inserted), TIME_W'(got.inserted));
      compare_field("evicted_valid", TIME_W'(want.evicted_valid),
                    TIME_W'(got.evicted_valid));
      compare_field("evicted_key", TIME_W'(want.evicted_key), TIME_W'(got.evicted_key));
      compare_field("hit_total", TIME_W'(want.hit_total), TIME_W'(got.hit_total));
      compare_field("miss_total", TIME_W'(want.miss_total), TIME_W'(got.miss_total));
      compare_field("time_total_ms", want.time_total_ms, got.time_total_ms);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CAP_W-1:0]      cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  req_type_i;
  logic [KEY_PORT_W-1:0] key_i;
  logic                  in_store_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  hit_o;
  logic                  inserted_o;
  logic                  evicted_valid_o;
  logic [KEY_PORT_W-1:0] evicted_key_o;
  logic [TOTAL_W-1:0]    hit_total_o;
  logic [TOTAL_W-1:0]    miss_total_o;
  logic [TIME_W-1:0]     time_total_ms_o;

  lfu_access_tracker tracker = new();
  bit                idle_on = 1'b1;
  bit                pressure_done = 1'b0;
  int unsigned       requests_seen = 0;
  int unsigned       cycle_count = 0;

  lfu_cache_replacement_top #(
    .ENTRIES  (ENTRIES_TB),
    .KEY_BITS (32)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .key_i           (key_i),
    .in_store_i      (in_store_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .inserted_o      (inserted_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_key_o   (evicted_key_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .time_total_ms_o (time_total_ms_o)
  );

  always #4 clk_i = ~clk_i;

  // Sample both handshakes on the edge and feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_request(req_type_i, key_i, in_store_i);
        requests_seen <= requests_seen + 1;
      end
      if (out_valid_o && out_ready_i)
        tracker.check_result({hit_o, inserted_o, evicted_valid_o, evicted_key_o,
                              hit_total_o, miss_total_o, time_total_ms_o});
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts plus one long hold-off to back up the block
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!pressure_done && requests_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(logic kind, logic [KEY_PORT_W-1:0] req_key, logic stored);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    key_i      <= req_key;
    in_store_i <= stored;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every outstanding request has returned
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.capacity = value;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [KEY_PORT_W-1:0] fill_keys[6];
    logic [KEY_PORT_W-1:0] key_pool[POOL_SIZE];
    logic [CAP_W-1:0]      phase_cap[PHASES];
    logic [KEY_PORT_W-1:0] k;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_READ;
    key_i       = '0;
    in_store_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: misses with and without store, hits, write hit and miss, full-key extremes
    write_capacity(4'd8);
    send_request(REQ_READ, 32'h0000_0000, 1'b0);
    send_request(REQ_READ, 32'h0000_0000, 1'b1);
    send_request(REQ_READ, 32'h0000_0000, 1'b1);
    send_request(REQ_WRITE, 32'h0000_0000, 1'b0);
    send_request(REQ_WRITE, 32'hFFFF_FFFF, 1'b1);
    send_request(REQ_READ, 32'hFFFF_FFFF, 1'b1);
    fill_keys = '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h1, 32'h2, 32'h4, 32'h8};
    foreach (fill_keys[i]) send_request(REQ_READ, fill_keys[i], 1'b1);
    // full cache: count ties go to the oldest stamp
    send_request(REQ_READ, 32'h8000_0000, 1'b1);
    send_request(REQ_READ, 32'hA5A5_A5A5, 1'b1);
    send_request(REQ_READ, 32'hA5A5_A5A5, 1'b0);
    send_request(REQ_READ, 32'h7FFF_FFFF, 1'b1);

    // Capacity below occupancy: one eviction per insert, hits unaffected
    write_capacity(4'd3);
    send_request(REQ_READ, 32'h0000_1234, 1'b1);
    send_request(REQ_READ, 32'h0000_0000, 1'b0);
    send_request(REQ_WRITE, 32'h0000_1234, 1'b0);

    // Caching disabled: write hit leaves entry alone, read miss never inserts
    write_capacity(4'd0);
    send_request(REQ_WRITE, 32'h0000_0000, 1'b1);
    send_request(REQ_READ, 32'h0000_0000, 1'b1);
    send_request(REQ_READ, 32'h0000_CAFE, 1'b1);

    // Capacity above the entry count clamps to the entry count
    write_capacity(4'd15);
    send_request(REQ_READ, 32'h0000_BEEF, 1'b1);
    send_request(REQ_READ, 32'h0000_CAFE, 1'b1);

    // Random phases over a small key pool so hits and evictions are frequent
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    phase_cap = '{4'd1, 4'd5, 4'd0, 4'd12, 4'd2, 4'd15, 4'd3, 4'd6, 4'd4, 4'd8};
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_cap[p]);
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int j = 0; j < 3; j++) key_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 19) < 17)
          k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          k = $urandom();
        send_request(($urandom_range(0, 3) == 0) ? REQ_WRITE : REQ_READ, k,
                     $urandom_range(0, 7) != 0);
      end
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
